### hdl/kpc_pkg.sv
// kpc_pkg: shared types, codes and constants for the keypad octal calculator
// no dependencies; imported by every module of the block
package kpc_pkg;

    localparam int VALUE_BITS      = 32;
    localparam int OUT_BITS        = 32;
    localparam int DIGIT_LIMIT_DEF = 20;

    // scan status codes
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_MULTI  = 2'd2;

    // key codes
    localparam logic [3:0] KEY_ADD = 4'hA;
    localparam logic [3:0] KEY_SUB = 4'hB;
    localparam logic [3:0] KEY_MUL = 4'hC;
    localparam logic [3:0] KEY_REG = 4'hF;

    // prior key value before any key was taken
    localparam logic [4:0] PRIOR_KEY_NONE = 5'd16;

    // result event codes
    localparam logic [1:0] EV_OPERAND = 2'd0;
    localparam logic [1:0] EV_RESULT  = 2'd1;
    localparam logic [1:0] EV_INVALID = 2'd2;
    localparam logic [1:0] EV_MULTI   = 2'd3;

    typedef struct packed {
        logic [1:0] scan_status;
        logic [3:0] key_code;
    } scan_t;

    typedef struct packed {
        logic [1:0]          event_res;
        logic [OUT_BITS-1:0] value;
        logic                range_error;
    } res_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL
    } alu_op_t;

    typedef struct packed {
        alu_op_t               op;
        logic [VALUE_BITS-1:0] a;
        logic [VALUE_BITS-1:0] b;
    } alu_in_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] result;
        logic                  range_error;
    } alu_out_t;

endpackage

### hdl/kpc_in_reg.sv
// kpc_in_reg: input register holding one accepted keypad scan beat
// depends on kpc_pkg
module kpc_in_reg
    import kpc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  scan_valid,
    output logic  scan_ready,
    input  scan_t scan,
    input  logic  advance,
    output logic  held_valid,
    output scan_t held
);

    logic  valid_reg;
    logic  valid_next;
    scan_t data_reg;

    assign scan_ready = !valid_reg || advance;
    assign valid_next = scan_valid ? 1'b1 : (valid_reg && !advance);
    assign held_valid = valid_reg;
    assign held       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (scan_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_valid && scan_ready)
        begin
            data_reg <= scan;
        end
    end

endmodule

### hdl/kpc_alu.sv
// kpc_alu: add, subtract and multiply of the two held operands with range flag
// depends on kpc_pkg
module kpc_alu
    import kpc_pkg::*;
(
    input  alu_in_t  alu_in,
    output alu_out_t alu_out
);

    logic [VALUE_BITS:0]     sum;
    logic [VALUE_BITS:0]     diff;
    logic [2*VALUE_BITS-1:0] prod;

    assign sum  = {1'b0, alu_in.a} + {1'b0, alu_in.b};
    assign diff = {1'b0, alu_in.a} - {1'b0, alu_in.b};
    assign prod = {{VALUE_BITS{1'b0}}, alu_in.a} * {{VALUE_BITS{1'b0}}, alu_in.b};

    always_comb
    begin
        unique case (alu_in.op)
            OP_ADD:
            begin
                alu_out.result      = sum[VALUE_BITS-1:0];
                alu_out.range_error = sum[VALUE_BITS];
            end
            OP_SUB:
            begin
                alu_out.result      = diff[VALUE_BITS-1:0];
                alu_out.range_error = diff[VALUE_BITS];
            end
            OP_MUL:
            begin
                alu_out.result      = prod[VALUE_BITS-1:0];
                alu_out.range_error = |prod[2*VALUE_BITS-1:VALUE_BITS];
            end
            default:
            begin
                alu_out.result      = '0;
                alu_out.range_error = 1'b0;
            end
        endcase
    end

endmodule

### hdl/kpc_core.sv
// kpc_core: key filter, entry and operand state, and result register
// depends on kpc_pkg; drives kpc_alu and advances kpc_in_reg
module kpc_core
    import kpc_pkg::*;
#(
    parameter int DIGIT_LIMIT = DIGIT_LIMIT_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     held_valid,
    input  scan_t    held,
    output logic     advance,
    output alu_in_t  alu_in,
    input  alu_out_t alu_out,
    output logic     res_valid,
    input  logic     res_ready,
    output res_t     res
);

    localparam int DC_W = $clog2(DIGIT_LIMIT + 1);

    logic [1:0]            prior_status_reg, prior_status_next;
    logic [4:0]            prior_key_reg, prior_key_next;
    logic [VALUE_BITS-1:0] entry_reg, entry_next;
    logic [DC_W-1:0]       digit_count_reg, digit_count_next;
    logic [1:0]            operand_count_reg, operand_count_next;
    logic [VALUE_BITS-1:0] first_reg, first_next;
    logic [VALUE_BITS-1:0] second_reg, second_next;
    logic                  res_valid_reg, res_valid_next;
    res_t                  res_reg, res_next;

    logic       take;
    logic       new_key;
    logic [1:0] st;
    logic [3:0] key;
    logic       is_op;

    assign advance   = !res_valid_reg || res_ready;
    assign take      = held_valid && advance;
    assign st        = held.scan_status;
    assign key       = held.key_code;
    assign new_key   = (st == ST_SINGLE)
                       && ((prior_status_reg != st) || ({1'b0, key} != prior_key_reg));
    assign is_op     = (key == KEY_ADD) || (key == KEY_SUB) || (key == KEY_MUL);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign alu_in.op = (key == KEY_ADD) ? OP_ADD : ((key == KEY_SUB) ? OP_SUB : OP_MUL);
    assign alu_in.a  = first_reg;
    assign alu_in.b  = second_reg;

    always_comb
    begin
        prior_status_next  = prior_status_reg;
        prior_key_next     = prior_key_reg;
        entry_next         = entry_reg;
        digit_count_next   = digit_count_reg;
        operand_count_next = operand_count_reg;
        first_next         = first_reg;
        second_next        = second_reg;
        res_valid_next     = res_valid_reg && !res_ready;
        res_next           = res_reg;

        if (take)
        begin
            prior_status_next = st;
            if (new_key)
            begin
                prior_key_next = {1'b0, key};
                if (key == KEY_REG)
                begin
                    if (operand_count_reg != 2'd2)
                    begin
                        if (operand_count_reg == 2'd0)
                        begin
                            first_next = entry_reg;
                        end
                        else
                        begin
                            second_next = entry_reg;
                        end
                        operand_count_next   = operand_count_reg + 2'd1;
                        entry_next           = '0;
                        digit_count_next     = '0;
                        res_valid_next       = 1'b1;
                        res_next.event_res   = EV_OPERAND;
                        res_next.value       = OUT_BITS'(entry_reg);
                        res_next.range_error = 1'b0;
                    end
                end
                else if (!key[3])
                begin
                    if (digit_count_reg < DC_W'(DIGIT_LIMIT))
                    begin
                        digit_count_next = digit_count_reg + DC_W'(1);
                        if (|entry_reg[VALUE_BITS-1:VALUE_BITS-3])
                        begin
                            entry_next = '1;
                        end
                        else
                        begin
                            entry_next = {entry_reg[VALUE_BITS-4:0], key[2:0]};
                        end
                    end
                end
                else if ((operand_count_reg == 2'd2) && is_op)
                begin
                    operand_count_next   = 2'd0;
                    res_valid_next       = 1'b1;
                    res_next.event_res   = EV_RESULT;
                    res_next.value       = OUT_BITS'(alu_out.result);
                    res_next.range_error = alu_out.range_error;
                end
                else
                begin
                    res_valid_next       = 1'b1;
                    res_next.event_res   = EV_INVALID;
                    res_next.value       = '0;
                    res_next.range_error = 1'b0;
                end
            end
            else if ((st == ST_MULTI) && (prior_status_reg != ST_MULTI))
            begin
                res_valid_next       = 1'b1;
                res_next.event_res   = EV_MULTI;
                res_next.value       = '0;
                res_next.range_error = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_status_reg  <= ST_NONE;
            prior_key_reg     <= PRIOR_KEY_NONE;
            entry_reg         <= '0;
            digit_count_reg   <= '0;
            operand_count_reg <= 2'd0;
            first_reg         <= '0;
            second_reg        <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            prior_status_reg  <= prior_status_next;
            prior_key_reg     <= prior_key_next;
            entry_reg         <= entry_next;
            digit_count_reg   <= digit_count_next;
            operand_count_reg <= operand_count_next;
            first_reg         <= first_next;
            second_reg        <= second_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

### hdl/keypad_octal_calculator.sv
// keypad_octal_calculator: top level of the keypad-driven octal calculator
// depends on kpc_pkg, kpc_in_reg, kpc_alu and kpc_core
//
// Takes one keypad scan beat per clock and gives at most one result beat per scan.
// Each scan is captured in the input register and, once the result register is free,
// processed by the key filter, entry/operand state and the 32-bit adder, subtractor
// and multiplier, which load the result register; a result beat is offered from the
// result register after its scan beat passes through the input register. Sustained
// rate is one scan per cycle while results are taken, set by that single pass from
// input register to result register. While a result beat is stalled nothing is
// processed: the input register can still capture one scan, then scan_ready stays
// low until the result is taken. Scans that give no result leave the output idle.
module keypad_octal_calculator
    import kpc_pkg::*;
#(
    parameter int DIGIT_LIMIT = DIGIT_LIMIT_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  scan_valid,
    output logic  scan_ready,
    input  scan_t scan,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    logic     held_valid;
    scan_t    held;
    logic     advance;
    alu_in_t  alu_in;
    alu_out_t alu_out;

    kpc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_ready (scan_ready),
        .scan       (scan),
        .advance    (advance),
        .held_valid (held_valid),
        .held       (held)
    );

    kpc_alu u_alu (
        .alu_in  (alu_in),
        .alu_out (alu_out)
    );

    kpc_core #(
        .DIGIT_LIMIT (DIGIT_LIMIT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held       (held),
        .advance    (advance),
        .alu_in     (alu_in),
        .alu_out    (alu_out),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule

### hdl/kpc_checker.sv
// kpc_checker: port-level assertions for keypad_octal_calculator, bound to the top
// depends on kpc_pkg
module kpc_checker
    import kpc_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  scan_valid,
    input logic  scan_ready,
    input logic  res_valid,
    input logic  res_ready,
    input res_t  res
);

    // range flag only on computed results
    a_flag_only_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.event_res != EV_RESULT)) |-> !res.range_error)
        else $error("range_error set on non-result event");

    // error events carry a zero value
    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && ((res.event_res == EV_INVALID) || (res.event_res == EV_MULTI)))
        |-> (res.value == '0))
        else $error("nonzero value on error event");

    // a fresh result follows an accepted scan beat
    a_result_has_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(scan_valid && scan_ready, 2))
        else $error("result without a matching scan beat");

    // stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("result beat changed while stalled");

endmodule

bind keypad_octal_calculator kpc_checker u_kpc_checker (.*);

### sim/kpc_result_check.sv
// kpc_result_check: watches the scan and result channels of the keypad octal calculator,
// predicts each result from the accepted scans and compares it field by field
// depends on kpc_pkg
`timescale 1ns / 1ps
module kpc_result_check
    import kpc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  scan_valid,
    input  logic  scan_ready,
    input  scan_t scan,
    input  logic  res_valid,
    input  logic  res_ready,
    input  res_t  res,
    output int    failures,
    output int    pending
);

    localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [3:0]  OCTAL_MAX  = 4'd7;
    localparam int          PRINT_MAX  = 100;

    logic [1:0]  prev_status;
    logic [4:0]  prev_key;
    logic [63:0] entry;
    int          digits;
    int          operands;
    logic [63:0] opnd_a;
    logic [63:0] opnd_b;
    res_t        expected_results[$];

    task automatic report(input string what, input logic [63:0] got_v, input logic [63:0] want_v);
        failures++;
        if (failures <= PRINT_MAX)
            $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got_v, want_v);
    endtask

    // advances the calculator state by one scan; returns 1 when the scan gives a result
    function automatic bit predict_scan(input scan_t s, output res_t r);
        logic [1:0]  st;
        logic [3:0]  k;
        logic [63:0] d;
        bit          hit;
        st  = s.scan_status;
        k   = s.key_code;
        d   = {60'd0, k};
        r   = '0;
        hit = 1'b0;
        if (st == ST_SINGLE && (st != prev_status || {1'b0, k} != prev_key))
        begin
            prev_key = {1'b0, k};
            if (k == KEY_REG)
            begin
                if (operands < 2)
                begin
                    if (operands == 0)
                        opnd_a = entry & VALUE_MASK;
                    else
                        opnd_b = entry & VALUE_MASK;
                    r.event_res = EV_OPERAND;
                    r.value     = entry[OUT_BITS-1:0];
                    operands++;
                    entry  = '0;
                    digits = 0;
                    hit    = 1'b1;
                end
            end
            else if (k <= OCTAL_MAX)
            begin
                if (digits < DIGIT_LIMIT_DEF)
                begin
                    digits++;
                    if (entry > (VALUE_MASK - d) / 64'd8)
                        entry = VALUE_MASK;
                    else
                        entry = entry * 64'd8 + d;
                end
            end
            else if (operands == 2 && (k == KEY_ADD || k == KEY_SUB || k == KEY_MUL))
            begin
                r.event_res = EV_RESULT;
                if (k == KEY_ADD)
                begin
                    r.value       = OUT_BITS'((opnd_a + opnd_b) & VALUE_MASK);
                    r.range_error = opnd_a > VALUE_MASK - opnd_b;
                end
                else if (k == KEY_SUB)
                begin
                    r.value       = OUT_BITS'((opnd_a - opnd_b) & VALUE_MASK);
                    r.range_error = opnd_a < opnd_b;
                end
                else
                begin
                    r.value = OUT_BITS'((opnd_a * opnd_b) & VALUE_MASK);
                    if (opnd_b != 0)
                        r.range_error = opnd_a > VALUE_MASK / opnd_b;
                end
                operands = 0;
                hit      = 1'b1;
            end
            else
            begin
                r.event_res = EV_INVALID;
                hit         = 1'b1;
            end
        end
        else if (st == ST_MULTI && st != prev_status)
        begin
            r.event_res = EV_MULTI;
            hit         = 1'b1;
        end
        prev_status = st;
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            prev_status = ST_NONE;
            prev_key    = PRIOR_KEY_NONE;
            entry       = '0;
            digits      = 0;
            operands    = 0;
            opnd_a      = '0;
            opnd_b      = '0;
            failures    = 0;
            expected_results.delete();
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                got = res;
                if (expected_results.size() == 0)
                    report("unexpected result beat, value", 64'(got.value), 64'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.event_res !== want.event_res)
                        report("event_res", 64'(got.event_res), 64'(want.event_res));
                    if (got.value !== want.value)
                        report("value", 64'(got.value), 64'(want.value));
                    if (got.range_error !== want.range_error)
                        report("range_error", 64'(got.range_error), 64'(want.range_error));
                end
            end
            if (scan_valid && scan_ready)
            begin
                if (predict_scan(scan, want))
                    expected_results.push_back(want);
            end
        end
        pending = expected_results.size();
    end

endmodule

### sim/testbench.sv
// testbench: drives keypad scans with random gaps and result stalls into the calculator
// depends on kpc_pkg, keypad_octal_calculator and kpc_result_check
`timescale 1ns / 1ps
module testbench;
    import kpc_pkg::*;

    localparam int         PLAN_ITEMS    = 1050;
    localparam int         MAX_GAP       = 13;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 32;
    localparam logic [1:0] ST_SPARE      = 2'd3;

    logic  clk;
    logic  rst_n;
    logic  scan_valid;
    logic  scan_ready;
    scan_t scan;
    logic  res_valid;
    logic  res_ready;
    res_t  res;
    int    failures;
    int    pending;
    int    idle_cycles;
    bit    steady;

    scan_t      scan_plan[$];
    logic [1:0] gen_status;
    logic [3:0] gen_key;

    keypad_octal_calculator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_ready (scan_ready),
        .scan       (scan),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    kpc_result_check result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_ready (scan_ready),
        .scan       (scan),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .failures   (failures),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic plan_scan(input logic [1:0] st, input logic [3:0] k);
        scan_t item;
        item.scan_status = st;
        item.key_code    = k;
        scan_plan.push_back(item);
        gen_status = st;
        if (st == ST_SINGLE)
            gen_key = k;
    endtask

    // a key press that the block takes, with separators and key bounce around it
    task automatic plan_key(input logic [3:0] k);
        if ((gen_status == ST_SINGLE && gen_key == k) || $urandom_range(0, 5) == 0)
            plan_scan(ST_NONE, 4'($urandom));
        plan_scan(ST_SINGLE, k);
        if ($urandom_range(0, 7) == 0)
            plan_scan(ST_SINGLE, k);
    endtask

    task automatic plan_operand();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 11);
        repeat (n) plan_key(4'($urandom_range(0, 7)));
        plan_key(KEY_REG);
    endtask

    task automatic plan_stimulus();
        gen_status = ST_NONE;
        gen_key    = 4'd0;
        plan_scan(ST_MULTI, 4'h0);
        plan_scan(ST_MULTI, KEY_REG);
        plan_scan(ST_SPARE, 4'h5);
        plan_scan(ST_SINGLE, KEY_ADD);
        plan_scan(ST_NONE, 4'h0);
        plan_scan(ST_SINGLE, KEY_REG);
        plan_scan(ST_SINGLE, 4'h7);
        plan_scan(ST_SINGLE, 4'h0);
        plan_scan(ST_SINGLE, 4'h7);
        plan_scan(ST_SINGLE, KEY_REG);
        plan_scan(ST_SINGLE, KEY_REG);
        plan_scan(ST_NONE, 4'hF);
        plan_scan(ST_SINGLE, KEY_REG);
        plan_scan(ST_SINGLE, KEY_SUB);
        plan_scan(ST_SINGLE, 4'h8);
        plan_scan(ST_SINGLE, 4'h9);
        plan_scan(ST_SINGLE, 4'hD);
        plan_scan(ST_SINGLE, 4'hE);
        plan_scan(ST_MULTI, 4'hE);
        plan_scan(ST_SINGLE, 4'hE);
        plan_scan(ST_SINGLE, KEY_MUL);
        while (scan_plan.size() < PLAN_ITEMS)
        begin
            case ($urandom_range(0, 9))
                6:
                begin
                    plan_operand();
                    plan_key(KEY_ADD + 4'($urandom_range(0, 2)));
                end
                7:
                    repeat ($urandom_range(1, 8))
                    begin
                        plan_scan(2'($urandom), 4'($urandom));
                    end
                8:
                    repeat ($urandom_range(1, 3))
                    begin
                        plan_scan(ST_MULTI, 4'($urandom));
                    end
                default:
                begin
                    plan_operand();
                    plan_operand();
                    if ($urandom_range(0, 5) == 0)
                        plan_operand();
                    if ($urandom_range(0, 9) == 0)
                        plan_key(4'($urandom_range(8, 14)));
                    else
                        plan_key(KEY_ADD + 4'($urandom_range(0, 2)));
                end
            endcase
        end
    endtask

    task automatic send_scan(input scan_t item, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            scan_valid <= 1'b0;
        end
        @(negedge clk);
        scan_valid <= 1'b1;
        scan       <= item;
        do @(posedge clk); while (!scan_ready);
    endtask

    initial
    begin : drain
        int stall;
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            repeat (stall)
            begin
                @(negedge clk);
                res_ready <= 1'b0;
            end
            @(negedge clk);
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (scan_valid && scan_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int gap;
        rst_n       = 1'b0;
        scan_valid  = 1'b0;
        scan        = '0;
        steady      = 1'b0;
        plan_stimulus();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (scan_plan[i])
        begin
            if (i % 100 == 50)
                steady = ($urandom_range(0, 3) == 0);
            gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            send_scan(scan_plan[i], gap);
        end
        @(negedge clk);
        scan_valid <= 1'b0;
        steady = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
